// ----- design/mfq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the message queue with type purge.
// No dependencies; every other design file refers to this package by scope.

package mfq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int QCNT_W  = 5;
    localparam int TYPE_W  = 16;
    localparam int ARG_W   = 32;

    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_FLUSH  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_START  = 3'd4,
        CMD_ABORT  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_EMPTY   = 2'd1,
        STS_ABORTED = 2'd2,
        STS_FULL    = 2'd3
    } status_t;

    // Which payload a result carries
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_MEM  = 2'd1,
        SEL_ENQ  = 2'd2
    } sel_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_EXEC     = 3'd1,
        ST_PURGE_RD = 3'd2,
        ST_PURGE_WR = 3'd3,
        ST_RESP_A   = 3'd4,
        ST_RESP_B   = 3'd5
    } state_t;

    typedef struct packed {
        logic [2:0]               command;
        logic [TYPE_W-1:0]        msg_type;
        logic signed [ARG_W-1:0]  first_arg;
        logic signed [ARG_W-1:0]  second_arg;
        logic                     wait_if_empty;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     is_delivery;
        logic [TYPE_W-1:0]        out_type;
        logic signed [ARG_W-1:0]  out_first_arg;
        logic signed [ARG_W-1:0]  out_second_arg;
        logic [QCNT_W-1:0]        queued_count;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic [TYPE_W-1:0]        msg_type;
        logic signed [ARG_W-1:0]  first_arg;
        logic signed [ARG_W-1:0]  second_arg;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_item;
        logic    enq;
        logic    deq;
        logic    flush;
        logic    set_abort;
        logic    clr_abort;
        logic    set_wait;
        logic    clr_wait;
        logic    rd_head;
        logic    purge_init;
        logic    purge_rd;
        logic    purge_wr;
        logic    purge_end;
        logic    emit;
        status_t emit_status;
        logic    emit_deliv;
        sel_t    emit_sel;
        logic    emit_last;
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] command;
        logic       wait_if_empty;
        logic       aborted;
        logic       waiting;
        logic       empty;
        logic       full;
        logic       scan_done;
        logic       out_free;
    } sts_t;

    // Ring position base + off, wrapped once; off never exceeds DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- design/mfq_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: message ring memory, head/count, flags, purge walker, result register.
// Depends on mfq_pkg.

module mfq_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfq_pkg::in_item_t s_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              m_ready,
    output logic              m_valid,
    output mfq_pkg::out_item_t m_data,
    input  mfq_pkg::ctl_t     ctl,
    output mfq_pkg::sts_t     sts
);

    mfq_pkg::entry_t mem [mfq_pkg::DEPTH];

    mfq_pkg::in_item_t          item_reg;
    mfq_pkg::entry_t            rd_data_reg;
    logic [mfq_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [mfq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [mfq_pkg::CNT_W-1:0]  scan_reg, scan_next;
    logic [mfq_pkg::CNT_W-1:0]  kept_reg, kept_next;
    logic                       aborted_reg, aborted_next;
    logic                       waiting_reg, waiting_next;
    logic [mfq_pkg::TYPE_W-1:0] marker_reg;
    logic                       m_valid_reg, m_valid_next;
    mfq_pkg::out_item_t         m_data_reg, m_data_next;

    mfq_pkg::entry_t            enq_entry;
    mfq_pkg::entry_t            wr_entry;
    logic [mfq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
    logic                       wr_en, rd_en, keep_entry;

    // Start enqueues the marker with zero arguments, put enqueues the item
    always_comb begin
        if (mfq_pkg::cmd_t'(item_reg.command) == mfq_pkg::CMD_START) begin
            enq_entry.msg_type   = marker_reg;
            enq_entry.first_arg  = '0;
            enq_entry.second_arg = '0;
        end else begin
            enq_entry.msg_type   = item_reg.msg_type;
            enq_entry.first_arg  = item_reg.first_arg;
            enq_entry.second_arg = item_reg.second_arg;
        end
    end

    assign keep_entry = (rd_data_reg.msg_type != item_reg.msg_type);
    assign wr_en      = ctl.enq || (ctl.purge_wr && keep_entry);
    assign wr_addr    = ctl.purge_wr ? mfq_pkg::ring_add(head_reg, kept_reg)
                                     : mfq_pkg::ring_add(head_reg, count_reg);
    assign wr_entry   = ctl.purge_wr ? rd_data_reg : enq_entry;
    assign rd_en      = ctl.rd_head || ctl.purge_rd;
    assign rd_addr    = ctl.purge_rd ? mfq_pkg::ring_add(head_reg, scan_reg) : head_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctl.load_item) begin
            item_reg <= s_data;
        end
    end

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        kept_next    = kept_reg;
        aborted_next = aborted_reg;
        waiting_next = waiting_reg;
        if (ctl.enq) begin
            count_next = count_reg + 1'b1;
        end
        if (ctl.deq) begin
            head_next  = mfq_pkg::ring_add(head_reg, mfq_pkg::CNT_W'(1));
            count_next = count_reg - 1'b1;
        end
        if (ctl.flush) begin
            head_next  = '0;
            count_next = '0;
        end
        if (ctl.purge_init) begin
            scan_next = '0;
            kept_next = '0;
        end
        if (ctl.purge_wr) begin
            scan_next = scan_reg + 1'b1;
            if (keep_entry) begin
                kept_next = kept_reg + 1'b1;
            end
        end
        if (ctl.purge_end) begin
            count_next = kept_reg;
        end
        if (ctl.set_abort) begin
            aborted_next = 1'b1;
        end
        if (ctl.clr_abort) begin
            aborted_next = 1'b0;
        end
        if (ctl.set_wait) begin
            waiting_next = 1'b1;
        end
        if (ctl.clr_wait) begin
            waiting_next = 1'b0;
        end
    end

    // Result register: the count shown is the one left after the whole item
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (ctl.emit) begin
            m_valid_next             = 1'b1;
            m_data_next.status       = ctl.emit_status;
            m_data_next.is_delivery  = ctl.emit_deliv;
            m_data_next.queued_count = mfq_pkg::QCNT_W'(count_reg);
            m_data_next.last         = ctl.emit_last;
            case (ctl.emit_sel)
                mfq_pkg::SEL_MEM: begin
                    m_data_next.out_type       = rd_data_reg.msg_type;
                    m_data_next.out_first_arg  = rd_data_reg.first_arg;
                    m_data_next.out_second_arg = rd_data_reg.second_arg;
                end
                mfq_pkg::SEL_ENQ: begin
                    m_data_next.out_type       = enq_entry.msg_type;
                    m_data_next.out_first_arg  = enq_entry.first_arg;
                    m_data_next.out_second_arg = enq_entry.second_arg;
                end
                default: begin
                    m_data_next.out_type       = '0;
                    m_data_next.out_first_arg  = '0;
                    m_data_next.out_second_arg = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            scan_reg    <= '0;
            kept_reg    <= '0;
            aborted_reg <= 1'b1;
            waiting_reg <= 1'b0;
            marker_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            kept_reg    <= kept_next;
            aborted_reg <= aborted_next;
            waiting_reg <= waiting_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                marker_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.command       = item_reg.command;
    assign sts.wait_if_empty = item_reg.wait_if_empty;
    assign sts.aborted       = aborted_reg;
    assign sts.waiting       = waiting_reg;
    assign sts.empty         = (count_reg == '0);
    assign sts.full          = (count_reg == mfq_pkg::CNT_W'(mfq_pkg::DEPTH));
    assign sts.scan_done     = (scan_reg == count_reg);
    assign sts.out_free      = !m_valid_reg || m_ready;

endmodule

// ----- design/mfq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: decodes each item, sequences the purge walk and the results.
// Depends on mfq_pkg.

module mfq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mfq_pkg::sts_t     sts,
    output mfq_pkg::ctl_t     ctl
);

    mfq_pkg::state_t  state_reg, state_next;
    mfq_pkg::status_t r1_status_reg, r1_status_next;
    mfq_pkg::sel_t    r1_sel_reg, r1_sel_next;
    mfq_pkg::status_t r2_status_reg, r2_status_next;
    mfq_pkg::sel_t    r2_sel_reg, r2_sel_next;
    logic             two_reg, two_next;
    logic             silent;

    // A get that starts waiting gives no result at all
    assign silent = (mfq_pkg::cmd_t'(sts.command) == mfq_pkg::CMD_GET) && !sts.aborted
                    && sts.empty && sts.wait_if_empty && !sts.waiting;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mfq_pkg::ST_EXEC;
                end
            end
            mfq_pkg::ST_EXEC: begin
                if (silent) begin
                    state_next = mfq_pkg::ST_IDLE;
                end else if (mfq_pkg::cmd_t'(sts.command) == mfq_pkg::CMD_REMOVE
                             && !sts.aborted) begin
                    state_next = mfq_pkg::ST_PURGE_RD;
                end else begin
                    state_next = mfq_pkg::ST_RESP_A;
                end
            end
            mfq_pkg::ST_PURGE_RD: begin
                state_next = sts.scan_done ? mfq_pkg::ST_RESP_A : mfq_pkg::ST_PURGE_WR;
            end
            mfq_pkg::ST_PURGE_WR: begin
                state_next = mfq_pkg::ST_PURGE_RD;
            end
            mfq_pkg::ST_RESP_A: begin
                if (sts.out_free) begin
                    state_next = two_reg ? mfq_pkg::ST_RESP_B : mfq_pkg::ST_IDLE;
                end
            end
            mfq_pkg::ST_RESP_B: begin
                if (sts.out_free) begin
                    state_next = mfq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl            = '0;
        s_ready        = 1'b0;
        r1_status_next = r1_status_reg;
        r1_sel_next    = r1_sel_reg;
        r2_status_next = r2_status_reg;
        r2_sel_next    = r2_sel_reg;
        two_next       = two_reg;
        case (state_reg)
            mfq_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ctl.load_item = s_valid;
            end
            mfq_pkg::ST_EXEC: begin
                r1_status_next = mfq_pkg::STS_OK;
                r1_sel_next    = mfq_pkg::SEL_NONE;
                r2_status_next = mfq_pkg::STS_OK;
                r2_sel_next    = mfq_pkg::SEL_NONE;
                two_next       = 1'b0;
                case (mfq_pkg::cmd_t'(sts.command))
                    mfq_pkg::CMD_PUT, mfq_pkg::CMD_START: begin
                        if (mfq_pkg::cmd_t'(sts.command) == mfq_pkg::CMD_PUT
                            && sts.aborted) begin
                            r1_status_next = mfq_pkg::STS_ABORTED;
                        end else if (sts.waiting) begin
                            // hand the message straight to the waiting reader
                            ctl.clr_wait = 1'b1;
                            two_next     = 1'b1;
                            r2_sel_next  = mfq_pkg::SEL_ENQ;
                        end else if (sts.full) begin
                            r1_status_next = mfq_pkg::STS_FULL;
                        end else begin
                            ctl.enq = 1'b1;
                        end
                        if (mfq_pkg::cmd_t'(sts.command) == mfq_pkg::CMD_START) begin
                            ctl.clr_abort = 1'b1;
                        end
                    end
                    mfq_pkg::CMD_GET: begin
                        if (sts.aborted) begin
                            r1_status_next = mfq_pkg::STS_ABORTED;
                        end else if (!sts.empty) begin
                            ctl.rd_head = 1'b1;
                            ctl.deq     = 1'b1;
                            r1_sel_next = mfq_pkg::SEL_MEM;
                        end else if (silent) begin
                            ctl.set_wait = 1'b1;
                        end else begin
                            r1_status_next = mfq_pkg::STS_EMPTY;
                        end
                    end
                    mfq_pkg::CMD_FLUSH: begin
                        ctl.flush = 1'b1;
                    end
                    mfq_pkg::CMD_REMOVE: begin
                        if (sts.aborted) begin
                            r1_status_next = mfq_pkg::STS_ABORTED;
                        end else begin
                            ctl.purge_init = 1'b1;
                        end
                    end
                    mfq_pkg::CMD_ABORT: begin
                        ctl.set_abort = 1'b1;
                        if (sts.waiting) begin
                            ctl.clr_wait   = 1'b1;
                            two_next       = 1'b1;
                            r2_status_next = mfq_pkg::STS_ABORTED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mfq_pkg::ST_PURGE_RD: begin
                ctl.purge_rd  = !sts.scan_done;
                ctl.purge_end = sts.scan_done;
            end
            mfq_pkg::ST_PURGE_WR: begin
                ctl.purge_wr = 1'b1;
            end
            mfq_pkg::ST_RESP_A: begin
                ctl.emit        = sts.out_free;
                ctl.emit_status = r1_status_reg;
                ctl.emit_sel    = r1_sel_reg;
                ctl.emit_deliv  = 1'b0;
                ctl.emit_last   = !two_reg;
            end
            mfq_pkg::ST_RESP_B: begin
                ctl.emit        = sts.out_free;
                ctl.emit_status = r2_status_reg;
                ctl.emit_sel    = r2_sel_reg;
                ctl.emit_deliv  = 1'b1;
                ctl.emit_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mfq_pkg::ST_IDLE;
            r1_status_reg <= mfq_pkg::STS_OK;
            r1_sel_reg    <= mfq_pkg::SEL_NONE;
            r2_status_reg <= mfq_pkg::STS_OK;
            r2_sel_reg    <= mfq_pkg::SEL_NONE;
            two_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            r1_status_reg <= r1_status_next;
            r1_sel_reg    <= r1_sel_next;
            r2_status_reg <= r2_status_next;
            r2_sel_reg    <= r2_sel_next;
            two_reg       <= two_next;
        end
    end

endmodule

// ----- design/message_fifo_with_type_purge_top.sv -----
`timescale 1ns / 1ps
// Top level of the message queue with type purge: controller plus datapath.
// Depends on mfq_pkg, mfq_ctrl and mfq_dpath.
//
//   Channel   Ports                         Direction  Transfer
//   -------   ----------------------------  ---------  ---------------------------
//   command   s_valid, s_ready, s_data      in         valid & ready at clock edge
//   result    m_valid, m_ready, m_data      out        valid & ready at clock edge
//   config    cfg_wr_en, cfg_wr_data        in         every edge with cfg_wr_en
//
// One item at a time: accept, decode/execute, then the results one after another, so
// put, get, flush, start and abort give one result (two with a delivery); a get that
// starts waiting gives no result. Remove walks the stored messages through the single
// memory read port, reading each in ST_PURGE_RD and writing it back, if kept, in
// ST_PURGE_WR. Reset (aresetn, synchronous, low) empties the queue, marks it aborted
// and clears the marker type. A stalled result register holds the sequencer in its
// result state; no new item is taken until all results of the current item have
// entered the result register.

module message_fifo_with_type_purge_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mfq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mfq_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);

    mfq_pkg::ctl_t ctl;
    mfq_pkg::sts_t sts;

    // Sequence each item: decide the outcome, drive the purge walk, emit results
    mfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Hold the ring, pointers, flags and the result register
    mfq_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule
